@@ sv/dptw_pkg.sv @@
`timescale 1ns / 1ps
package dptw_pkg;

  localparam int IDX_W = 12;   // sample index
  localparam int PER_W = 13;   // period / buffer length registers
  localparam int K_W   = 12;   // triangle ramp position
  localparam int AMP_W = 16;   // DAC word
  localparam int NUM_W = 29;   // |amp| * 2 * k
  localparam int QUO_W = 16;   // quotient magnitude (never above 32768)
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    MODE_DC    = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_TRI   = 2'd2
  } mode_t;

  localparam logic [2:0] REG_WAVE_MODE   = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [2:0] REG_BUF_LEN     = 3'd2;
  localparam logic [2:0] REG_PERIOD      = 3'd3;
  localparam logic [2:0] REG_ON_SAMPLES  = 3'd4;
  localparam logic [2:0] REG_PATH_ENABLE = 3'd5;
  localparam logic [2:0] REG_CHANNEL_SEL = 3'd6;

  typedef struct packed {
    logic last;
    logic ch;
    logic pulse_on;
  } side_t;

  typedef struct packed {
    logic [PER_W-1:0] rem_p;
    logic [PER_W-1:0] rem_h;
    logic [IDX_W-1:0] num;
    side_t            side;
  } mod_t;

  typedef struct packed {
    logic [PER_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic             neg;
    side_t            side;
  } div_t;

endpackage

@@ sv/dc_pulse_triangle_wave_gen.sv @@
`timescale 1ns / 1ps
// Path from input transfer to result: 12 modulo cells, ramp stage, multiply stage,
//   29 divide cells, output register.
// Throughput: one sample per cycle; the whole cell row advances whenever the
//   output register is empty or being taken.
// Reset (synchronous, rst_n low): pipeline empty, configuration registers take their defaults.
module dc_pulse_triangle_wave_gen import dptw_pkg::*; #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CHANNELS    = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // sample index in
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IDX_W-1:0]        in_sample_index,
  // DAC words out
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [AMP_W-1:0] out_inphase_sample,
  output logic signed [AMP_W-1:0] out_quad_sample,
  output logic                    out_channel,
  output logic                    out_last_sample
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [1:0]       wave_mode_r;
  logic [AMP_W-1:0] amplitude_r;
  logic [PER_W-1:0] buf_len_r;
  logic [PER_W-1:0] period_r;
  logic [PER_W-1:0] on_r;
  logic [1:0]       path_en_r;
  logic             ch_sel_r;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r <= MODE_DC;
      amplitude_r <= '0;
      buf_len_r   <= PER_W'(4096);
      period_r    <= PER_W'(4096);
      on_r        <= '0;
      path_en_r   <= 2'd2;
      ch_sel_r    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVE_MODE:   wave_mode_r <= pwdata[1:0];
        REG_AMPLITUDE:   amplitude_r <= pwdata[AMP_W-1:0];
        REG_BUF_LEN:     buf_len_r   <= pwdata[PER_W-1:0];
        REG_PERIOD:      period_r    <= pwdata[PER_W-1:0];
        REG_ON_SAMPLES:  on_r        <= pwdata[PER_W-1:0];
        REG_PATH_ENABLE: path_en_r   <= pwdata[1:0];
        REG_CHANNEL_SEL: ch_sel_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAVE_MODE:   prdata = {30'b0, wave_mode_r};
      REG_AMPLITUDE:   prdata = {{(32-AMP_W){amplitude_r[AMP_W-1]}}, amplitude_r};
      REG_BUF_LEN:     prdata = {{(32-PER_W){1'b0}}, buf_len_r};
      REG_PERIOD:      prdata = {{(32-PER_W){1'b0}}, period_r};
      REG_ON_SAMPLES:  prdata = {{(32-PER_W){1'b0}}, on_r};
      REG_PATH_ENABLE: prdata = {30'b0, path_en_r};
      REG_CHANNEL_SEL: prdata = {31'b0, ch_sel_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Global advance: the row moves when the output slot frees up
  // ---------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = out_ready || !out_valid_r;
  assign in_ready = adv;

  logic [PER_W-1:0] half;
  assign half = {1'b0, period_r[PER_W-1:1]};

  // last flag and channel slot, resolved at entry
  localparam int LEN_W = 18;
  logic [LEN_W-1:0] len_cap;
  logic             last_in;
  logic [2:0]       ch_lim;
  logic             ch_in;

  always_comb begin
    if ({{(LEN_W-PER_W){1'b0}}, buf_len_r} > LEN_W'(MAX_SAMPLES)) begin
      len_cap = LEN_W'(MAX_SAMPLES);
    end else begin
      len_cap = {{(LEN_W-PER_W){1'b0}}, buf_len_r};
    end
    last_in = (len_cap != '0) &&
              (({{(LEN_W-IDX_W){1'b0}}, in_sample_index} + LEN_W'(1)) == len_cap);
    ch_lim = 3'(CHANNELS);
    if ({2'b0, ch_sel_r} >= ch_lim) begin
      ch_in = 1'(ch_lim - 3'd1);
    end else begin
      ch_in = ch_sel_r;
    end
  end

  // ---------------------------------------------------------------
  // Modulo cell row: i mod P and i mod P/2
  // ---------------------------------------------------------------
  logic mod_v [0:IDX_W];
  mod_t mod_d [0:IDX_W];

  always_comb begin
    mod_v[0] = in_valid;
    mod_d[0].rem_p = '0;
    mod_d[0].rem_h = '0;
    mod_d[0].num   = in_sample_index;
    mod_d[0].side.last     = last_in;
    mod_d[0].side.ch       = ch_in;
    mod_d[0].side.pulse_on = 1'b0;
  end

  for (genvar g = 0; g < IDX_W; g++) begin : g_mod
    dptw_mod_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (mod_v[g]),
      .d_i    (mod_d[g]),
      .per_i  (period_r),
      .half_i (half),
      .vld_o  (mod_v[g+1]),
      .d_o    (mod_d[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Ramp stage: triangle position k and the pulse gate
  // ---------------------------------------------------------------
  logic           k_v_r;
  logic [K_W-1:0] k_r;
  logic [K_W-1:0] k_nxt;
  side_t          k_side_r;
  side_t          k_side_nxt;
  mod_t           m_end;

  assign m_end = mod_d[IDX_W];

  always_comb begin
    if (period_r == '0 || half == '0) begin
      k_nxt = '0;
    end else if (m_end.rem_p < half) begin
      k_nxt = m_end.rem_h[K_W-1:0];
    end else begin
      k_nxt = K_W'(half - m_end.rem_h);
    end
    k_side_nxt = m_end.side;
    k_side_nxt.pulse_on = (period_r != '0) && (m_end.rem_p < on_r) &&
                          (path_en_r == 2'd0 || path_en_r == 2'd2);
  end

  // multiply stage: |amp| * 2k
  logic             mul_v_r;
  logic [NUM_W-1:0] mul_r;
  logic             mul_neg_r;
  side_t            mul_side_r;
  logic [AMP_W-1:0] amp_mag;
  logic [27:0]      prod;

  assign amp_mag = amplitude_r[AMP_W-1] ? AMP_W'(-amplitude_r) : amplitude_r;
  assign prod    = {12'b0, amp_mag} * {16'b0, k_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r   <= 1'b0;
      mul_v_r <= 1'b0;
    end else if (adv) begin
      k_v_r   <= mod_v[IDX_W];
      mul_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r        <= k_nxt;
      k_side_r   <= k_side_nxt;
      mul_r      <= {prod, 1'b0};
      mul_neg_r  <= amplitude_r[AMP_W-1];
      mul_side_r <= k_side_r;
    end
  end

  // ---------------------------------------------------------------
  // Divide cell row: quotient of |amp|*2k by P, one bit per cell
  // ---------------------------------------------------------------
  logic div_v [0:NUM_W];
  div_t div_d [0:NUM_W];

  always_comb begin
    div_v[0]     = mul_v_r;
    div_d[0].rem = '0;
    div_d[0].num = mul_r;
    div_d[0].quo = '0;
    div_d[0].neg = mul_neg_r;
    div_d[0].side = mul_side_r;
  end

  for (genvar g = 0; g < NUM_W; g++) begin : g_div
    dptw_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (div_v[g]),
      .d_i   (div_d[g]),
      .per_i (period_r),
      .vld_o (div_v[g+1]),
      .d_o   (div_d[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Output register: pick the waveform word
  // ---------------------------------------------------------------
  div_t             d_end;
  logic [AMP_W-1:0] tri_w;
  logic [AMP_W-1:0] iv_nxt;
  logic [AMP_W-1:0] qv_nxt;

  assign d_end = div_d[NUM_W];

  always_comb begin
    tri_w = d_end.neg ? AMP_W'(-d_end.quo) : d_end.quo;
    iv_nxt = '0;
    qv_nxt = '0;
    case (wave_mode_r)
      MODE_DC: begin
        iv_nxt = amplitude_r;
        qv_nxt = amplitude_r;
      end
      MODE_PULSE: iv_nxt = d_end.side.pulse_on ? amplitude_r : '0;
      MODE_TRI:   iv_nxt = (period_r == '0) ? '0 : tri_w;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inphase_sample <= iv_nxt;
      out_quad_sample    <= qv_nxt;
      out_channel        <= d_end.side.ch;
      out_last_sample    <= d_end.side.last;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_dc_iq_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wave_mode_r == MODE_DC |-> out_inphase_sample == out_quad_sample)
    else $error("dc mode: I and Q differ");

  a_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wave_mode_r != MODE_DC |-> out_quad_sample == '0)
    else $error("quadrature word nonzero outside dc mode");

  a_tri_zero_amp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wave_mode_r == MODE_TRI && amplitude_r == '0 |-> out_inphase_sample == '0)
    else $error("triangle nonzero with zero amplitude");
`endif

endmodule

@@ sv/dptw_mod_cell.sv @@
`timescale 1ns / 1ps
// One restoring step of i mod P and i mod P/2, sharing the dividend bit.
module dptw_mod_cell import dptw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  mod_t             d_i,
  input  logic [PER_W-1:0] per_i,
  input  logic [PER_W-1:0] half_i,
  output logic             vld_o,
  output mod_t             d_o
);

  logic             vld_r;
  mod_t             d_r;
  mod_t             d_nxt;
  logic [PER_W:0]   tp;
  logic [PER_W:0]   th;

  always_comb begin
    tp = {d_i.rem_p, d_i.num[IDX_W-1]};
    th = {d_i.rem_h, d_i.num[IDX_W-1]};
    d_nxt = d_i;
    d_nxt.num = {d_i.num[IDX_W-2:0], 1'b0};
    if (tp >= {1'b0, per_i}) begin
      d_nxt.rem_p = PER_W'(tp - {1'b0, per_i});
    end else begin
      d_nxt.rem_p = tp[PER_W-1:0];
    end
    if (th >= {1'b0, half_i}) begin
      d_nxt.rem_h = PER_W'(th - {1'b0, half_i});
    end else begin
      d_nxt.rem_h = th[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

@@ sv/dptw_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring division step: one quotient bit per cell.
module dptw_div_cell import dptw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  div_t             d_i,
  input  logic [PER_W-1:0] per_i,
  output logic             vld_o,
  output div_t             d_o
);

  logic           vld_r;
  div_t           d_r;
  div_t           d_nxt;
  logic [PER_W:0] t;
  logic           ge;

  always_comb begin
    t  = {d_i.rem, d_i.num[NUM_W-1]};
    ge = (t >= {1'b0, per_i});
    d_nxt = d_i;
    d_nxt.num = {d_i.num[NUM_W-2:0], 1'b0};
    d_nxt.quo = {d_i.quo[QUO_W-2:0], ge};
    if (ge) begin
      d_nxt.rem = PER_W'(t - {1'b0, per_i});
    end else begin
      d_nxt.rem = t[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
